### src/dhkpd_pkg.sv
// Shared types, codes, constants and tables for the dual H-bridge kick-start drive.
package dhkpd_pkg;

    // Speed command full scale.
    localparam int SPEED_MAX = 100;

    // Full duty in percent.
    localparam logic [6:0] FULL_PCT = 7'd100;

    // Widths of the datapath.
    localparam int WRAP_W  = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = WRAP_W + PCT_W;
    localparam int ADDR_W  = 3;

    // Division of the product by 100: floor(p / 100) = (p * RECIP_100) >> DIV_SHIFT
    // for every product below 2^PROD_W.
    localparam int DIV_SHIFT = 30;
    localparam int RECIP_W   = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int QPROD_W   = PROD_W + RECIP_W;

    // Command codes.
    localparam logic [1:0] CMD_SPEED = 2'd0;
    localparam logic [1:0] CMD_RAW   = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Channel codes.
    localparam logic [1:0] CH_LEFT  = 2'd1;
    localparam logic [1:0] CH_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_CNT_TOP       = 3'd0;
    localparam logic [ADDR_W-1:0] REG_REVERSE_LEFT  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_REVERSE_RIGHT = 3'd2;
    localparam logic [ADDR_W-1:0] REG_KICK_TICKS    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_KICK_DUTY_PCT = 3'd4;
    localparam logic [ADDR_W-1:0] REG_MIN_RUN_PCT   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [WRAP_W-1:0] RST_CNT_TOP       = 16'd99;
    localparam logic [7:0]        RST_KICK_TICKS    = 8'd3;
    localparam logic [PCT_W-1:0]  RST_KICK_DUTY_PCT = 7'd80;
    localparam logic [PCT_W-1:0]  RST_MIN_RUN_PCT   = 7'd30;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic [WRAP_W-1:0] cnt_top;
        logic              reverse_left;
        logic              reverse_right;
        logic [7:0]        kick_ticks;
        logic [PCT_W-1:0]  kick_duty_pct;
        logic [PCT_W-1:0]  min_run_pct;
    } cfg_t;

    // Work handed from the duty stage to the output stage.
    typedef struct packed {
        op_t               op;
        logic              accepted;
        logic              pin_a;
        logic              pin_b;
        logic              full;
        logic [PROD_W-1:0] product;
    } drv_t;

    typedef struct packed {
        logic              accepted;
        logic              left_in_a;
        logic              left_in_b;
        logic [WRAP_W-1:0] left_level;
        logic              right_in_a;
        logic              right_in_b;
        logic [WRAP_W-1:0] right_level;
    } res_t;

    // Speed magnitude to duty percent, clamped to SPEED_MAX and truncated.
    typedef logic [255:0][PCT_W-1:0] pct_tab_t;

    function automatic pct_tab_t build_speed_pct();
        pct_tab_t t;
        int m;
        for (int i = 0; i < 256; i++) begin
            m = (i > SPEED_MAX) ? SPEED_MAX : i;
            t[i] = PCT_W'((m * 100) / SPEED_MAX);
        end
        return t;
    endfunction

    localparam pct_tab_t SPEED_PCT = build_speed_pct();

endpackage

### src/dhkpd_cfg.sv
// Configuration register file of the drive.
module dhkpd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dhkpd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [dhkpd_pkg::WRAP_W-1:0]  cfg_wr_data,
    output dhkpd_pkg::cfg_t               cfg
);

    dhkpd_pkg::cfg_t cfg_reg;
    dhkpd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                dhkpd_pkg::REG_CNT_TOP:       cfg_next.cnt_top       = cfg_wr_data;
                dhkpd_pkg::REG_REVERSE_LEFT:  cfg_next.reverse_left  = cfg_wr_data[0];
                dhkpd_pkg::REG_REVERSE_RIGHT: cfg_next.reverse_right = cfg_wr_data[0];
                dhkpd_pkg::REG_KICK_TICKS:    cfg_next.kick_ticks    = cfg_wr_data[7:0];
                dhkpd_pkg::REG_KICK_DUTY_PCT: cfg_next.kick_duty_pct = cfg_wr_data[6:0];
                dhkpd_pkg::REG_MIN_RUN_PCT:   cfg_next.min_run_pct   = cfg_wr_data[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cnt_top       <= dhkpd_pkg::RST_CNT_TOP;
            cfg_reg.reverse_left  <= 1'b0;
            cfg_reg.reverse_right <= 1'b0;
            cfg_reg.kick_ticks    <= dhkpd_pkg::RST_KICK_TICKS;
            cfg_reg.kick_duty_pct <= dhkpd_pkg::RST_KICK_DUTY_PCT;
            cfg_reg.min_run_pct   <= dhkpd_pkg::RST_MIN_RUN_PCT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/dhkpd_duty.sv
// Command decode, kick-start state and duty selection with the level product.
module dhkpd_duty (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [1:0]            cmd,
    input  logic [1:0]            channel,
    input  logic [7:0]            value,
    input  dhkpd_pkg::cfg_t       cfg,
    output dhkpd_pkg::drv_t       drv
);

    dhkpd_pkg::dir_t dir_reg  [2];
    dhkpd_pkg::dir_t dir_next;
    logic [7:0]      kick_reg [2];
    logic [7:0]      kick_next;

    logic                        ch_ok;
    logic                        ch_idx;
    logic [7:0]                  abs_val;
    logic [dhkpd_pkg::PCT_W-1:0] speed_pct;
    logic [dhkpd_pkg::PCT_W-1:0] raw_mag;
    logic                        fwd;
    logic                        load;
    logic [7:0]                  kc;
    logic [dhkpd_pkg::PCT_W-1:0] run_pct;
    logic [dhkpd_pkg::PCT_W-1:0] smag;
    logic [dhkpd_pkg::PCT_W-1:0] mag;
    logic                        neg_pre;
    logic                        neg;
    logic                        rev;
    logic                        speed_upd;
    dhkpd_pkg::op_t              op_sel;
    logic                        acc_sel;

    assign ch_ok     = (channel == dhkpd_pkg::CH_LEFT) || (channel == dhkpd_pkg::CH_RIGHT);
    assign ch_idx    = (channel == dhkpd_pkg::CH_RIGHT);
    assign abs_val   = value[7] ? (~value + 8'd1) : value;
    assign speed_pct = dhkpd_pkg::SPEED_PCT[abs_val];
    assign raw_mag   = (abs_val > 8'(dhkpd_pkg::FULL_PCT)) ? dhkpd_pkg::FULL_PCT
                                                          : abs_val[6:0];
    assign fwd       = !value[7];
    assign rev       = ch_idx ? cfg.reverse_right : cfg.reverse_left;

    // Kick-start: a start from rest or a reversal reloads the counter.
    assign load    = (dir_reg[ch_idx] == dhkpd_pkg::DIR_STOP)
                  || (fwd != (dir_reg[ch_idx] == dhkpd_pkg::DIR_FWD));
    assign kc      = load ? cfg.kick_ticks : kick_reg[ch_idx];
    assign run_pct = (speed_pct < cfg.min_run_pct) ? cfg.min_run_pct : speed_pct;

    always_comb begin
        if (speed_pct == '0) begin
            smag      = '0;
            kick_next = '0;
            dir_next  = dhkpd_pkg::DIR_STOP;
        end else if (kc != '0) begin
            smag      = cfg.kick_duty_pct;
            kick_next = kc - 8'd1;
            dir_next  = fwd ? dhkpd_pkg::DIR_FWD : dhkpd_pkg::DIR_REV;
        end else begin
            smag      = run_pct;
            kick_next = kc;
            dir_next  = fwd ? dhkpd_pkg::DIR_FWD : dhkpd_pkg::DIR_REV;
        end
    end

    always_comb begin
        op_sel    = dhkpd_pkg::OP_NONE;
        acc_sel   = 1'b0;
        mag       = '0;
        neg_pre   = 1'b0;
        speed_upd = 1'b0;
        case (cmd)
            dhkpd_pkg::CMD_SPEED: begin
                if (ch_ok) begin
                    op_sel    = ch_idx ? dhkpd_pkg::OP_RIGHT : dhkpd_pkg::OP_LEFT;
                    acc_sel   = 1'b1;
                    mag       = (smag > dhkpd_pkg::FULL_PCT) ? dhkpd_pkg::FULL_PCT : smag;
                    neg_pre   = !fwd;
                    speed_upd = 1'b1;
                end
            end
            dhkpd_pkg::CMD_RAW: begin
                if (ch_ok) begin
                    op_sel  = ch_idx ? dhkpd_pkg::OP_RIGHT : dhkpd_pkg::OP_LEFT;
                    acc_sel = 1'b1;
                    mag     = raw_mag;
                    neg_pre = value[7];
                end
            end
            dhkpd_pkg::CMD_STOP: begin
                op_sel  = dhkpd_pkg::OP_STOP;
                acc_sel = 1'b1;
            end
            default: begin
                op_sel  = dhkpd_pkg::OP_NONE;
                acc_sel = 1'b0;
            end
        endcase
    end

    assign neg = neg_pre ^ rev;

    always_comb begin
        drv.op       = op_sel;
        drv.accepted = acc_sel;
        drv.pin_a    = (mag != '0) && !neg;
        drv.pin_b    = (mag != '0) && neg;
        drv.full     = (mag >= dhkpd_pkg::FULL_PCT);
        drv.product  = dhkpd_pkg::PROD_W'(mag) * dhkpd_pkg::PROD_W'(cfg.cnt_top);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg[0]  <= dhkpd_pkg::DIR_STOP;
            dir_reg[1]  <= dhkpd_pkg::DIR_STOP;
            kick_reg[0] <= '0;
            kick_reg[1] <= '0;
        end else if (advance && speed_upd) begin
            dir_reg[ch_idx]  <= dir_next;
            kick_reg[ch_idx] <= kick_next;
        end
    end

endmodule

### src/dhkpd_drive.sv
// Level scaling and the held pin and level state of both channels.
module dhkpd_drive (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  dhkpd_pkg::drv_t               drv,
    input  logic [dhkpd_pkg::WRAP_W-1:0]  cnt_top,
    output dhkpd_pkg::res_t               res
);

    dhkpd_pkg::res_t res_reg;
    dhkpd_pkg::res_t res_next;

    logic [dhkpd_pkg::QPROD_W-1:0] qprod;
    logic [dhkpd_pkg::WRAP_W-1:0]  level;

    // Divide by 100 through the reciprocal; the quotient stays below 2^16.
    assign qprod = dhkpd_pkg::QPROD_W'(drv.product) * dhkpd_pkg::QPROD_W'(dhkpd_pkg::RECIP_100);
    assign level = drv.full ? (cnt_top + 16'd1) : qprod[dhkpd_pkg::DIV_SHIFT +: dhkpd_pkg::WRAP_W];

    always_comb begin
        res_next          = res_reg;
        res_next.accepted = drv.accepted;
        case (drv.op)
            dhkpd_pkg::OP_LEFT: begin
                res_next.left_in_a  = drv.pin_a;
                res_next.left_in_b  = drv.pin_b;
                res_next.left_level = level;
            end
            dhkpd_pkg::OP_RIGHT: begin
                res_next.right_in_a  = drv.pin_a;
                res_next.right_in_b  = drv.pin_b;
                res_next.right_level = level;
            end
            dhkpd_pkg::OP_STOP: begin
                res_next.left_in_a   = 1'b0;
                res_next.left_in_b   = 1'b0;
                res_next.left_level  = '0;
                res_next.right_in_a  = 1'b0;
                res_next.right_in_b  = 1'b0;
                res_next.right_level = '0;
            end
            default: begin
                res_next.left_in_a = res_reg.left_in_a;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/dual_hbridge_kickstart_pwm_drive_core.sv
// Top level of the two-channel H-bridge PWM drive with kick-start.
//
//   Channel   Direction  Ports                                   Handshake
//   command   in         s_cmd, s_channel, s_value               s_valid / s_ready
//   result    out        m_accepted, m_left_*, m_right_*         m_valid / m_ready
//   config    in         cfg_addr, cfg_wr_data                   cfg_wr_en, no wait
//
// A command's result is formed in order as it moves on: the input register feeds
// the duty stage (kick logic and the 7 x 16 bit level product), whose register feeds
// the output stage (reciprocal divide by 100 and the held channel state).
// One command is taken every cycle that s_ready is high; s_ready falls only when all
// three stages are full and the result is not being taken.
// Reset is synchronous and active low; it restores the register defaults, clears
// the kick state and drives both channels to coast with a zero level.
module dual_hbridge_kickstart_pwm_drive_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [1:0]                    s_channel,
    input  logic signed [7:0]             s_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic                          m_left_in_a,
    output logic                          m_left_in_b,
    output logic [dhkpd_pkg::WRAP_W-1:0]  m_left_level,
    output logic                          m_right_in_a,
    output logic                          m_right_in_b,
    output logic [dhkpd_pkg::WRAP_W-1:0]  m_right_level,

    input  logic                          cfg_wr_en,
    input  logic [dhkpd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [dhkpd_pkg::WRAP_W-1:0]  cfg_wr_data
);

    dhkpd_pkg::cfg_t cfg;
    dhkpd_pkg::drv_t drv_comb;
    dhkpd_pkg::drv_t drv_reg;
    dhkpd_pkg::res_t res;

    // Input register.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] cmd_reg;
    logic [1:0] channel_reg;
    logic [7:0] value_reg;

    // Duty stage and result valid flags.
    logic drv_valid_reg;
    logic drv_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic s_xfer;
    logic adv_drv;
    logic adv_out;

    // A stage moves on when it holds a command and the stage after it is empty or
    // moving on in the same cycle. The kick state and the held channel state are
    // updated only on those moves, so each command acts exactly once and in order.
    assign adv_out = drv_valid_reg && (!out_valid_reg || m_ready);
    assign adv_drv = in_valid_reg && (!drv_valid_reg || adv_out);
    assign s_ready = !in_valid_reg || adv_drv;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (adv_drv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        drv_valid_next = drv_valid_reg;
        if (adv_drv) begin
            drv_valid_next = 1'b1;
        end else if (adv_out) begin
            drv_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            drv_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            drv_valid_reg <= drv_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg     <= s_cmd;
            channel_reg <= s_channel;
            value_reg   <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_drv) begin
            drv_reg <= drv_comb;
        end
    end

    dhkpd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    dhkpd_duty u_duty (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (adv_drv),
        .cmd     (cmd_reg),
        .channel (channel_reg),
        .value   (value_reg),
        .cfg     (cfg),
        .drv     (drv_comb)
    );

    dhkpd_drive u_drive (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv_out),
        .drv      (drv_reg),
        .cnt_top  (cfg.cnt_top),
        .res      (res)
    );

    // The result register doubles as the held output state of both channels.
    assign m_valid       = out_valid_reg;
    assign m_accepted    = res.accepted;
    assign m_left_in_a   = res.left_in_a;
    assign m_left_in_b   = res.left_in_b;
    assign m_left_level  = res.left_level;
    assign m_right_in_a  = res.right_in_a;
    assign m_right_in_b  = res.right_in_b;
    assign m_right_level = res.right_level;

endmodule
